/* hw/rtl/psxpad_pkg.sv */
// ----------------------------------------------------------------------------
// psxpad_pkg: shared types and constants for the pad link device
// Request and result layouts, command codes, mode IDs and reply helpers.
// ----------------------------------------------------------------------------
package psxpad_pkg;

  // Pad operating mode.
  typedef enum logic [1:0] {
    MODE_PLAIN    = 2'd0,
    MODE_STICKS   = 2'd1,
    MODE_PRESSURE = 2'd2
  } pad_mode_e;

  // Command codes sent by the console.
  localparam logic [7:0] CMD_FRAME_OPEN = 8'h01;
  localparam logic [7:0] CMD_SET_PRESS  = 8'h40;
  localparam logic [7:0] CMD_QUERY_MASK = 8'h41;
  localparam logic [7:0] CMD_READ_PAD   = 8'h42;
  localparam logic [7:0] CMD_CFG_MODE   = 8'h43;
  localparam logic [7:0] CMD_SET_MODE   = 8'h44;
  localparam logic [7:0] CMD_QUERY_MODEL = 8'h45;
  localparam logic [7:0] CMD_QUERY_ACT  = 8'h46;
  localparam logic [7:0] CMD_QUERY_COMB = 8'h47;
  localparam logic [7:0] CMD_QUERY_MODE = 8'h4C;
  localparam logic [7:0] CMD_MOTOR_MAP  = 8'h4D;
  localparam logic [7:0] CMD_PRESS_CFG  = 8'h4F;

  // Reply bytes with a fixed meaning.
  localparam logic [7:0] ID_DIGITAL  = 8'h41;
  localparam logic [7:0] ID_ANALOG   = 8'h73;
  localparam logic [7:0] ID_PRESSURE = 8'h79;
  localparam logic [7:0] ID_CONFIG   = 8'hF3;
  localparam logic [7:0] REPLY_MARK  = 8'h5A;
  localparam logic [7:0] LOCK_CODE   = 8'h03;

  // Reply lengths in bytes, counting the marker byte.
  localparam logic [4:0] LEN_DIGITAL  = 5'd3;
  localparam logic [4:0] LEN_ANALOG   = 5'd7;
  localparam logic [4:0] LEN_PRESSURE = 5'd19;
  localparam logic [4:0] LEN_CONFIG   = 5'd7;

  // Eight pad bytes, first byte in the lowest bits.
  typedef struct packed {
    logic [7:0] r2_pressure;
    logic [7:0] l2_pressure;
    logic [7:0] left_y;
    logic [7:0] left_x;
    logic [7:0] right_y;
    logic [7:0] right_x;
    logic [7:0] buttons_high;
    logic [7:0] buttons_low;
  } pad_data_t;

  // One received byte together with its pad data.
  typedef struct packed {
    logic       frame_start;
    pad_data_t  pad;
    logic [7:0] rx_byte;
  } pad_request_t;

  // One reply byte and the state flags after it.
  typedef struct packed {
    logic       mode_locked;
    logic       in_config;
    logic [1:0] pad_mode;
    logic       ack;
    logic [7:0] tx_byte;
  } pad_result_t;

  // Mode ID sent in answer to the frame opening byte.
  function automatic logic [7:0] mode_id(logic cfg, pad_mode_e mode);
    logic [7:0] id;
    if (cfg) begin
      id = ID_CONFIG;
    end else begin
      case (mode)
        MODE_PLAIN:    id = ID_DIGITAL;
        MODE_PRESSURE: id = ID_PRESSURE;
        default:       id = ID_ANALOG;
      endcase
    end
    return id;
  endfunction

  // Length of the pad data reply in the given mode.
  function automatic logic [4:0] pad_len(pad_mode_e mode);
    logic [4:0] len;
    case (mode)
      MODE_PLAIN:    len = LEN_DIGITAL;
      MODE_PRESSURE: len = LEN_PRESSURE;
      default:       len = LEN_ANALOG;
    endcase
    return len;
  endfunction

  // Pressure byte for a digital button: full when the active-low bit is clear.
  function automatic logic [7:0] press_of(logic [7:0] v, logic [7:0] mask);
    return ((v & mask) != 8'h00) ? 8'h00 : 8'hFF;
  endfunction

  // Pad data byte at reply position i (position zero is the marker).
  function automatic logic [7:0] pad_byte(pad_data_t s, logic [4:0] i);
    logic [7:0] b;
    case (i)
      5'd0:  b = REPLY_MARK;
      5'd1:  b = s.buttons_low;
      5'd2:  b = s.buttons_high;
      5'd3:  b = s.right_x;
      5'd4:  b = s.right_y;
      5'd5:  b = s.left_x;
      5'd6:  b = s.left_y;
      5'd7:  b = press_of(s.buttons_low, 8'h20);
      5'd8:  b = press_of(s.buttons_low, 8'h80);
      5'd9:  b = press_of(s.buttons_low, 8'h10);
      5'd10: b = press_of(s.buttons_low, 8'h40);
      5'd11: b = press_of(s.buttons_high, 8'h10);
      5'd12: b = press_of(s.buttons_high, 8'h20);
      5'd13: b = press_of(s.buttons_high, 8'h40);
      5'd14: b = press_of(s.buttons_high, 8'h80);
      5'd15: b = press_of(s.buttons_high, 8'h04);
      5'd16: b = press_of(s.buttons_high, 8'h08);
      5'd17: b = s.l2_pressure;
      5'd18: b = s.r2_pressure;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/psxpad_core.sv */
// ----------------------------------------------------------------------------
// psxpad_core: frame tracking, pad state and reply selection
// Holds the protocol state and works out one reply byte per request.
// ----------------------------------------------------------------------------
module psxpad_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  psxpad_pkg::pad_request_t req_i,
  output psxpad_pkg::pad_result_t  res_o
);
  import psxpad_pkg::*;

  logic [4:0] pos_q, pos_d;
  logic       active_q, active_d;
  logic [7:0] cmd_q, cmd_d;
  pad_mode_e  mode_q, mode_d;
  logic       cfg_q, cfg_d;
  logic       lock_q, lock_d;
  logic       press_q, press_d;
  logic [7:0] map_q [6];
  logic [7:0] map_d [6];
  logic [7:0] ofs_q, ofs_d;
  pad_data_t  snap_q, snap_d;
  logic [4:0] len_q, len_d;
  logic       cfg_reply_q, cfg_reply_d;

  logic [4:0] idx;
  logic [4:0] nxt;
  logic [7:0] reply;
  logic [7:0] tx;
  logic       ack;
  logic       dig;
  logic       zoff;
  logic [2:0] map_sel;

  assign idx     = pos_q - 5'd2;
  assign nxt     = idx + 5'd1;
  assign dig     = (mode_d == MODE_PLAIN);
  assign zoff    = (ofs_d == 8'h00);
  assign map_sel = 3'(nxt - 5'd1);

  // Reply byte at position nxt for the running command, seen after this byte.
  always_comb begin
    reply = 8'h00;
    if (nxt <= 5'd18) begin
      case (cmd_q)
        CMD_READ_PAD: reply = pad_byte(snap_q, nxt);
        CMD_CFG_MODE: reply = cfg_reply_q ? 8'h00 : pad_byte(snap_q, nxt);
        CMD_SET_PRESS: begin
          if (nxt == 5'd3) reply = 8'h02;
          else if (nxt == 5'd6) reply = REPLY_MARK;
        end
        CMD_QUERY_MASK: begin
          if (!dig) begin
            case (nxt)
              5'd1, 5'd2: reply = 8'hFF;
              5'd3:       reply = 8'h03;
              5'd6:       reply = REPLY_MARK;
              default:    reply = 8'h00;
            endcase
          end
        end
        CMD_QUERY_MODEL: begin
          case (nxt)
            5'd1:    reply = 8'h03;
            5'd2:    reply = 8'h02;
            5'd3:    reply = dig ? 8'h00 : 8'h01;
            5'd4:    reply = 8'h02;
            5'd5:    reply = 8'h01;
            default: reply = 8'h00;
          endcase
        end
        CMD_QUERY_ACT: begin
          case (nxt)
            5'd3:    reply = 8'h01;
            5'd4:    reply = zoff ? 8'h02 : 8'h01;
            5'd5:    reply = zoff ? 8'h00 : 8'h01;
            5'd6:    reply = 8'h0F;
            default: reply = 8'h00;
          endcase
        end
        CMD_QUERY_COMB: begin
          if (nxt == 5'd3) reply = 8'h02;
          else if (nxt == 5'd5) reply = 8'h01;
        end
        CMD_QUERY_MODE: begin
          if (nxt == 5'd4) reply = zoff ? 8'h04 : 8'h07;
        end
        CMD_MOTOR_MAP: begin
          if (nxt >= 5'd1 && nxt <= 5'd6) reply = map_d[map_sel];
        end
        CMD_PRESS_CFG: begin
          if (nxt == 5'd6) reply = REPLY_MARK;
        end
        default: reply = 8'h00;
      endcase
    end
  end

  // Next state and reply for one received byte.
  always_comb begin
    pos_d       = pos_q;
    active_d    = active_q;
    cmd_d       = cmd_q;
    mode_d      = mode_q;
    cfg_d       = cfg_q;
    lock_d      = lock_q;
    press_d     = press_q;
    map_d       = map_q;
    ofs_d       = ofs_q;
    snap_d      = snap_q;
    len_d       = len_q;
    cfg_reply_d = cfg_reply_q;
    tx          = 8'h00;
    ack         = 1'b0;

    if (req_i.frame_start) begin
      // Frame opening byte: answer with the mode ID if it is a valid opener.
      pos_d    = 5'd1;
      active_d = (req_i.rx_byte == CMD_FRAME_OPEN);
      if (active_d) begin
        tx  = mode_id(cfg_q, mode_q);
        ack = 1'b1;
      end
    end else if (active_q) begin
      if (pos_q <= 5'd1) begin
        // Command byte: sample the pad and decide the reply length.
        cmd_d  = req_i.rx_byte;
        snap_d = req_i.pad;
        case (req_i.rx_byte)
          CMD_READ_PAD: begin
            cfg_d = 1'b0;
            len_d = pad_len(mode_q);
          end
          CMD_CFG_MODE: begin
            cfg_reply_d = cfg_q;
            len_d       = cfg_q ? LEN_CONFIG : pad_len(mode_q);
          end
          CMD_SET_PRESS, CMD_QUERY_MASK, CMD_SET_MODE, CMD_QUERY_MODEL,
          CMD_QUERY_ACT, CMD_QUERY_COMB, CMD_QUERY_MODE, CMD_MOTOR_MAP,
          CMD_PRESS_CFG: begin
            len_d = cfg_q ? LEN_CONFIG : 5'd0;
          end
          default: len_d = 5'd0;
        endcase
        if (len_d == 5'd0) begin
          active_d = 1'b0;
        end else begin
          tx  = REPLY_MARK;
          ack = 1'b1;
        end
      end else begin
        // Data byte: apply what the console sent for the running command.
        case (cmd_q)
          CMD_CFG_MODE: begin
            if (idx == 5'd1) cfg_d = (req_i.rx_byte != 8'h00);
          end
          CMD_SET_MODE: begin
            if (idx == 5'd1) begin
              if (req_i.rx_byte == CMD_FRAME_OPEN) begin
                mode_d = press_q ? MODE_PRESSURE : MODE_STICKS;
              end else begin
                mode_d = MODE_PLAIN;
              end
            end else if (idx == 5'd2) begin
              lock_d = (req_i.rx_byte == LOCK_CODE);
            end
          end
          CMD_QUERY_ACT, CMD_QUERY_MODE: begin
            if (idx == 5'd1) ofs_d = req_i.rx_byte;
          end
          CMD_MOTOR_MAP: begin
            for (int k = 0; k < 6; k++) begin
              if (idx == 5'(k + 1)) map_d[k] = req_i.rx_byte;
            end
          end
          CMD_PRESS_CFG: begin
            if (idx == 5'd1) begin
              press_d = (req_i.rx_byte != 8'h00);
            end else if (idx >= 5'd2 && idx <= 5'd4) begin
              press_d = press_q | (req_i.rx_byte != 8'h00);
            end else if (idx == 5'd6) begin
              mode_d = press_q ? MODE_PRESSURE : MODE_STICKS;
            end
          end
          default: ;
        endcase
        if (nxt < len_q) begin
          tx  = reply;
          ack = 1'b1;
        end else begin
          active_d = 1'b0;
        end
      end
      pos_d = pos_q + 5'd1;
    end
  end

  // Result carries the state after this byte.
  always_comb begin
    res_o.tx_byte     = tx;
    res_o.ack         = ack;
    res_o.pad_mode    = mode_d;
    res_o.in_config   = cfg_d;
    res_o.mode_locked = lock_d;
  end

  // State registers, updated once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 5'd0;
      active_q    <= 1'b0;
      cmd_q       <= 8'h00;
      mode_q      <= MODE_STICKS;
      cfg_q       <= 1'b0;
      lock_q      <= 1'b0;
      press_q     <= 1'b1;
      for (int k = 0; k < 6; k++) map_q[k] <= 8'hFF;
      ofs_q       <= 8'h00;
      snap_q      <= '0;
      len_q       <= 5'd0;
      cfg_reply_q <= 1'b0;
    end else if (fire_i) begin
      pos_q       <= pos_d;
      active_q    <= active_d;
      cmd_q       <= cmd_d;
      mode_q      <= mode_d;
      cfg_q       <= cfg_d;
      lock_q      <= lock_d;
      press_q     <= press_d;
      map_q       <= map_d;
      ofs_q       <= ofs_d;
      snap_q      <= snap_d;
      len_q       <= len_d;
      cfg_reply_q <= cfg_reply_d;
    end
  end

endmodule

/* hw/rtl/psx_pad_device_protocol.sv */
// ----------------------------------------------------------------------------
// psx_pad_device_protocol: device side of the game pad serial link
// Takes one received byte per request and returns the next byte to drive.
// ----------------------------------------------------------------------------
// Path: an accepted request sits in the input register and its result is loaded
// into the result register once that register is free or being drained.
// Throughput: one request per cycle; the input register advances whenever the
// result register is empty or being taken, so both sides can stream together.
// Reset: asynchronous, active low; the pad starts in analog mode, out of config
// mode, with motor mapping all 0xFF and no frame open.
module psx_pad_device_protocol (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rx_byte, [15:8] buttons_low, [23:16] buttons_high, [31:24] right_x,
  // [39:32] right_y, [47:40] left_x, [55:48] left_y, [63:56] l2_pressure,
  // [71:64] r2_pressure
  input  logic [71:0] s_axis_tdata,
  // [0] frame_start
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] tx_byte, [8] ack, [10:9] pad_mode, [11] in_config, [12] mode_locked,
  // [15:13] zero
  output logic [15:0] m_axis_tdata
);
  import psxpad_pkg::*;

  logic         in_vld_q;
  pad_request_t in_q;
  logic         out_vld_q;
  pad_result_t  out_q;
  pad_result_t  res;
  logic         advance;
  logic         fire;

  // The input stage moves on when the result register is free or drained.
  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= {s_axis_tuser, s_axis_tdata};
    end
  end

  psxpad_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_q),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_q};

endmodule

/* hw/rtl/psxpad_checker.sv */
// ----------------------------------------------------------------------------
// psxpad_checker: port-level checks for the pad link device
// Watches the stream ports over time and flags broken behavior.
// ----------------------------------------------------------------------------
module psxpad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // With no result pending the block always takes a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request refused with empty result register");

  // A byte without acknowledge drives zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'h00)
    else $error("nonzero byte without acknowledge");

  // The mode field never reads the unused code and the spare bits stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[10:9] != 2'b11 && m_axis_tdata[15:13] == 3'b000)
    else $error("bad mode or padding in result");

endmodule

bind psx_pad_device_protocol psxpad_checker u_psxpad_checker (.*);

/* tb/psx_pad_device_protocol_tb.sv */
// ----------------------------------------------------------------------------
// psx_pad_device_protocol_tb: self-checking bench for the pad link device
// Sends console bytes as framed command sequences with random pad data and
// compares each reply byte and the mode flags against a cycle-free predictor.
// Both stream sides idle at random, and once the output stalls long enough
// to back the block up.
// ----------------------------------------------------------------------------
module psx_pad_device_protocol_tb;
  import psxpad_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned ITEM_COUNT   = 650;
  localparam int unsigned LONG_HOLD    = 150;
  localparam logic [7:0]  CMD_UNKNOWN  = 8'h48;

  // Predicts every reply byte and keeps the replies still owed by the block.
  class pad_reply_board;
    pad_result_t pending_replies[$];
    int unsigned failures;
    int unsigned seen_requests;

    logic [4:0]  byte_pos;
    logic        frame_open;
    logic [7:0]  cmd;
    pad_mode_e   mode;
    logic        cfg;
    logic        locked;
    logic        press_req;
    logic [7:0]  motor_map[6];
    logic [7:0]  act_offset;
    pad_data_t   snap;
    logic [4:0]  reply_len;
    logic        cfg_reply;

    function new();
      byte_pos      = '0;
      frame_open    = 1'b0;
      cmd           = '0;
      mode          = MODE_STICKS;
      cfg           = 1'b0;
      locked        = 1'b0;
      press_req     = 1'b1;
      foreach (motor_map[i]) motor_map[i] = 8'hFF;
      act_offset    = '0;
      snap          = '0;
      reply_len     = '0;
      cfg_reply     = 1'b0;
      failures      = 0;
      seen_requests = 0;
    endfunction

    // Reply length for a command, marker included; zero means refused.
    function logic [4:0] open_reply(logic [7:0] c);
      logic [4:0] data_len;
      data_len = (mode == MODE_PLAIN) ? LEN_DIGITAL :
                 (mode == MODE_PRESSURE) ? LEN_PRESSURE : LEN_ANALOG;
      case (c)
        CMD_READ_PAD: begin
          cfg = 1'b0;
          return data_len;
        end
        CMD_CFG_MODE: begin
          cfg_reply = cfg;
          return cfg ? LEN_CONFIG : data_len;
        end
        CMD_SET_PRESS, CMD_QUERY_MASK, CMD_SET_MODE, CMD_QUERY_MODEL,
        CMD_QUERY_ACT, CMD_QUERY_COMB, CMD_QUERY_MODE, CMD_MOTOR_MAP,
        CMD_PRESS_CFG: begin
          return cfg ? LEN_CONFIG : 5'd0;
        end
        default: return 5'd0;
      endcase
    endfunction

    // Pad data at a reply position: sticks, buttons, pressures, triggers.
    function logic [7:0] pad_reply(int idx);
      logic [7:0] src;
      logic [7:0] mask;
      if (idx >= 7 && idx <= 16) begin
        src = (idx <= 10) ? snap.buttons_low : snap.buttons_high;
        case (idx)
          7:  mask = 8'h20;
          8:  mask = 8'h80;
          9:  mask = 8'h10;
          10: mask = 8'h40;
          11: mask = 8'h10;
          12: mask = 8'h20;
          13: mask = 8'h40;
          14: mask = 8'h80;
          15: mask = 8'h04;
          default: mask = 8'h08;
        endcase
        // Active-low button: released reads zero pressure, pressed reads full.
        return ((src & mask) != 8'h00) ? 8'h00 : 8'hFF;
      end
      case (idx)
        1:  return snap.buttons_low;
        2:  return snap.buttons_high;
        3:  return snap.right_x;
        4:  return snap.right_y;
        5:  return snap.left_x;
        6:  return snap.left_y;
        17: return snap.l2_pressure;
        18: return snap.r2_pressure;
        default: return 8'h00;
      endcase
    endfunction

    // Reply byte at a position of the current command's answer.
    function logic [7:0] reply_at(int idx);
      logic digital;
      logic zero_off;
      digital  = (mode == MODE_PLAIN);
      zero_off = (act_offset == 8'h00);
      if (idx == 0) return REPLY_MARK;
      if (idx > 18) return 8'h00;
      case (cmd)
        CMD_READ_PAD:   return pad_reply(idx);
        CMD_CFG_MODE:   return cfg_reply ? 8'h00 : pad_reply(idx);
        CMD_SET_PRESS:  return (idx == 3) ? 8'h02 : (idx == 6) ? REPLY_MARK : 8'h00;
        CMD_QUERY_MASK: begin
          if (digital || idx >= 7) return 8'h00;
          case (idx)
            1, 2:    return 8'hFF;
            3:       return 8'h03;
            6:       return REPLY_MARK;
            default: return 8'h00;
          endcase
        end
        CMD_QUERY_MODEL: begin
          case (idx)
            1:       return 8'h03;
            2:       return 8'h02;
            3:       return digital ? 8'h00 : 8'h01;
            4:       return 8'h02;
            5:       return 8'h01;
            default: return 8'h00;
          endcase
        end
        CMD_QUERY_ACT: begin
          case (idx)
            3:       return 8'h01;
            4:       return zero_off ? 8'h02 : 8'h01;
            5:       return zero_off ? 8'h00 : 8'h01;
            6:       return 8'h0F;
            default: return 8'h00;
          endcase
        end
        CMD_QUERY_COMB: return (idx == 3) ? 8'h02 : (idx == 5) ? 8'h01 : 8'h00;
        CMD_QUERY_MODE: return (idx == 4) ? (zero_off ? 8'h04 : 8'h07) : 8'h00;
        CMD_MOTOR_MAP:  return (idx <= 6) ? motor_map[idx-1] : 8'h00;
        CMD_PRESS_CFG:  return (idx == 6) ? REPLY_MARK : 8'h00;
        default:        return 8'h00;
      endcase
    endfunction

    // State updates carried by a data byte of the current command.
    function void absorb(int idx, logic [7:0] v);
      case (cmd)
        CMD_CFG_MODE: begin
          if (idx == 1) cfg = (v != 8'h00);
        end
        CMD_SET_MODE: begin
          if (idx == 1) begin
            if (v == 8'h01) mode = press_req ? MODE_PRESSURE : MODE_STICKS;
            else mode = MODE_PLAIN;
          end else if (idx == 2) begin
            locked = (v == LOCK_CODE);
          end
        end
        CMD_QUERY_ACT, CMD_QUERY_MODE: begin
          if (idx == 1) act_offset = v;
        end
        CMD_MOTOR_MAP: begin
          if (idx >= 1 && idx <= 6) motor_map[idx-1] = v;
        end
        CMD_PRESS_CFG: begin
          if (idx == 1) press_req = (v != 8'h00);
          else if (idx >= 2 && idx <= 4) press_req = press_req | (v != 8'h00);
          else if (idx == 6) mode = press_req ? MODE_PRESSURE : MODE_STICKS;
        end
        default: ;
      endcase
    endfunction

    // Advance the device by one received byte and return its reply.
    function pad_result_t predict_reply(pad_request_t r);
      pad_result_t res;
      int idx;
      res = '0;
      seen_requests++;
      if (r.frame_start) begin
        byte_pos   = 5'd1;
        frame_open = (r.rx_byte == CMD_FRAME_OPEN);
        if (frame_open) begin
          res.ack = 1'b1;
          if (cfg) res.tx_byte = ID_CONFIG;
          else if (mode == MODE_PLAIN) res.tx_byte = ID_DIGITAL;
          else if (mode == MODE_PRESSURE) res.tx_byte = ID_PRESSURE;
          else res.tx_byte = ID_ANALOG;
        end
      end else if (frame_open) begin
        if (byte_pos <= 5'd1) begin
          // Command byte: pad data is captured here for the whole reply.
          cmd       = r.rx_byte;
          snap      = r.pad;
          reply_len = open_reply(r.rx_byte);
          if (reply_len == 5'd0) begin
            frame_open = 1'b0;
          end else begin
            res.tx_byte = REPLY_MARK;
            res.ack     = 1'b1;
          end
        end else begin
          idx = int'(byte_pos) - 2;
          absorb(idx, r.rx_byte);
          if (idx + 1 < int'(reply_len)) begin
            res.tx_byte = reply_at(idx + 1);
            res.ack     = 1'b1;
          end else begin
            frame_open = 1'b0;
          end
        end
        byte_pos = byte_pos + 5'd1;
      end
      res.pad_mode    = mode;
      res.in_config   = cfg;
      res.mode_locked = locked;
      return res;
    endfunction

    function void note_request(pad_request_t r);
      pending_replies.push_back(predict_reply(r));
    endfunction

    function void check_reply(logic [15:0] data);
      pad_result_t got;
      pad_result_t want;
      if (pending_replies.size() == 0) begin
        $error("reply 0x%h with no request pending", data);
        failures++;
        return;
      end
      got  = data[12:0];
      want = pending_replies.pop_front();
      if (got.tx_byte != want.tx_byte) begin
        $error("tx_byte: expected %h, got %h", want.tx_byte, got.tx_byte);
        failures++;
      end
      if (got.ack != want.ack) begin
        $error("ack: expected %b, got %b", want.ack, got.ack);
        failures++;
      end
      if (got.pad_mode != want.pad_mode) begin
        $error("pad_mode: expected %0d, got %0d", want.pad_mode, got.pad_mode);
        failures++;
      end
      if (got.in_config != want.in_config) begin
        $error("in_config: expected %b, got %b", want.in_config, got.in_config);
        failures++;
      end
      if (got.mode_locked != want.mode_locked) begin
        $error("mode_locked: expected %b, got %b", want.mode_locked, got.mode_locked);
        failures++;
      end
      if (data[15:13] != 3'b000) begin
        $error("spare bits: expected 0, got %b", data[15:13]);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  pad_reply_board board = new();
  int unsigned    cycle_count = 0;
  bit             send_calm = 1'b0;

  psx_pad_device_protocol i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("psx_pad_device_protocol verification failed");
      $finish;
    end
  end

  // Both handshakes are observed with the values present before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note_request({s_axis_tuser, s_axis_tdata});
      if (m_axis_tvalid && m_axis_tready) board.check_reply(m_axis_tdata);
    end
  end

  function automatic pad_request_t make_request(bit fs, logic [7:0] b, pad_data_t p);
    pad_request_t r;
    r.frame_start = fs;
    r.rx_byte     = b;
    r.pad         = p;
    return r;
  endfunction

  // Random pad data, now and then all released or all pressed.
  function automatic pad_data_t random_pad();
    pad_data_t p;
    p = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: p = '0;
      1: p = '1;
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 15))
      0, 1, 2: return CMD_READ_PAD;
      3, 4, 5: return CMD_CFG_MODE;
      6:       return CMD_SET_PRESS;
      7:       return CMD_QUERY_MASK;
      8:       return CMD_SET_MODE;
      9:       return CMD_QUERY_MODEL;
      10:      return CMD_QUERY_ACT;
      11:      return CMD_QUERY_COMB;
      12:      return CMD_QUERY_MODE;
      13:      return CMD_MOTOR_MAP;
      14:      return CMD_PRESS_CFG;
      default: return 8'($urandom);
    endcase
  endfunction

  // Data bytes favor the values that change state: 0x01, 0x03 and zero.
  function automatic logic [7:0] pick_data(logic [7:0] c, int idx);
    if (idx == 1) begin
      case ($urandom_range(0, 3))
        0: return 8'h01;
        1: return 8'h00;
        2: return LOCK_CODE;
        default: return 8'($urandom);
      endcase
    end
    if (idx == 2 && $urandom_range(0, 1) == 0) return LOCK_CODE;
    if (c == CMD_PRESS_CFG && $urandom_range(0, 3) != 0) return 8'h00;
    if ($urandom_range(0, 3) == 0) return 8'h00;
    return 8'($urandom);
  endfunction

  // Offer one request after a random gap and hold it until it is taken.
  task automatic offer(pad_request_t r);
    int gap;
    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.pad, r.rx_byte};
    s_axis_tuser  <= r.frame_start;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Mostly complete or cut command frames, some stray and bad-start bytes.
  task automatic send_frame();
    pad_request_t q[$];
    pad_data_t    pad;
    logic [7:0]   c;
    logic [7:0]   v;
    int           n;
    int           kind;
    kind = $urandom_range(0, 19);
    pad  = random_pad();
    if (kind == 0) begin
      repeat ($urandom_range(1, 3)) q.push_back(make_request(1'b0, 8'($urandom), random_pad()));
    end else if (kind == 1) begin
      v = 8'($urandom);
      if (v == CMD_FRAME_OPEN) v = 8'h00;
      q.push_back(make_request(1'b1, v, pad));
      repeat ($urandom_range(1, 4)) q.push_back(make_request(1'b0, pick_command(), pad));
    end else begin
      c = pick_command();
      q.push_back(make_request(1'b1, CMD_FRAME_OPEN, random_pad()));
      q.push_back(make_request(1'b0, c, pad));
      case ($urandom_range(0, 9))
        0, 1, 2: n = 7;
        3, 4:    n = 19;
        5:       n = 3;
        6:       n = 8;
        default: n = $urandom_range(0, 21);
      endcase
      for (int i = 0; i < n; i++) q.push_back(make_request(1'b0, pick_data(c, i), random_pad()));
    end
    foreach (q[i]) offer(q[i]);
  endtask

  // Stimulus: reset, directed cases, then random frames.
  initial begin
    pad_request_t q[$];
    pad_data_t    pz;
    pad_data_t    pf;
    pz = '0;
    pf = '1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Stray byte, then a bad frame start whose command is ignored.
    q.push_back(make_request(1'b0, CMD_FRAME_OPEN, pf));
    q.push_back(make_request(1'b1, 8'hFF, pf));
    q.push_back(make_request(1'b0, CMD_READ_PAD, pf));
    // Full analog poll with all buttons pressed and sticks at zero.
    q.push_back(make_request(1'b1, CMD_FRAME_OPEN, pf));
    q.push_back(make_request(1'b0, CMD_READ_PAD, pz));
    repeat (7) q.push_back(make_request(1'b0, 8'h00, pf));
    // Enter config mode, then a new frame start cuts that reply short.
    q.push_back(make_request(1'b1, CMD_FRAME_OPEN, pf));
    q.push_back(make_request(1'b0, CMD_CFG_MODE, pf));
    q.push_back(make_request(1'b0, 8'h00, pz));
    q.push_back(make_request(1'b0, 8'h01, pz));
    // Unknown command in config mode is refused.
    q.push_back(make_request(1'b1, CMD_FRAME_OPEN, pz));
    q.push_back(make_request(1'b0, CMD_UNKNOWN, pz));
    // Select pressure mode and lock it.
    q.push_back(make_request(1'b1, CMD_FRAME_OPEN, pz));
    q.push_back(make_request(1'b0, CMD_SET_MODE, pz));
    q.push_back(make_request(1'b0, 8'h00, pz));
    q.push_back(make_request(1'b0, 8'h01, pz));
    q.push_back(make_request(1'b0, LOCK_CODE, pf));
    foreach (q[i]) offer(q[i]);

    while (board.seen_requests < ITEM_COUNT) send_frame();
    s_axis_tvalid <= 1'b0;

    while (board.pending_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("psx_pad_device_protocol verification clean");
    end else begin
      $display("psx_pad_device_protocol verification failed");
    end
    $finish;
  end

  // Reply side: random stalls, calm stretches, and one long hold-off.
  initial begin
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 10);
      if (taken == 300) stall = LONG_HOLD;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

endmodule
